### rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RRTP_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define RRTP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/rrtp_pkg.sv
package rrtp_pkg;

	// Table sizes
	localparam int THREAD_SLOTS = 16;
	localparam int LOCK_COUNT   = 16;
	localparam int SLOT_W       = $clog2(THREAD_SLOTS);
	localparam int LOCK_W       = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;
	localparam int CNT_W        = $clog2(THREAD_SLOTS + 1);

	typedef logic [SLOT_W-1:0] slot_idx_t;
	typedef logic [LOCK_W-1:0] lock_idx_t;
	typedef logic [CNT_W-1:0]  used_cnt_t;

	// Payload field types
	typedef logic [2:0] op_field_t;
	typedef logic [3:0] slot_field_t;
	typedef logic [3:0] lock_field_t;

	typedef enum logic [2:0] {
		OP_TICK      = 3'd0,
		OP_ADMIT     = 3'd1,
		OP_SUSPEND   = 3'd2,
		OP_RESUME    = 3'd3,
		OP_BLOCK     = 3'd4,
		OP_TERMINATE = 3'd5,
		OP_FREE_LOCK = 3'd6
	} op_code_t;

	typedef enum logic [2:0] {
		MODE_READY      = 3'd0,
		MODE_RUNNING    = 3'd1,
		MODE_BLOCKED    = 3'd2,
		MODE_SUSPENDED  = 3'd3,
		MODE_TERMINATED = 3'd4
	} mode_t;

	typedef struct packed {
		op_field_t   operation;
		slot_field_t slot;
		lock_field_t lock_id;
	} cmd_item_t;

	typedef struct packed {
		slot_field_t picked_slot;
		logic        picked_idle;
		logic        first_entry;
		logic        switched;
	} pick_item_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_DEMOTE,
		ST_COMMIT,
		ST_EMIT
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load_in;
		logic exec;
		logic scan_step;
		logic demote;
		logic commit;
		logic emit;
	} dp_ctl_t;

	// Datapath to controller status
	typedef struct packed {
		logic      in_tick;
		logic      hit;
		logic      out_free;
		used_cnt_t used_cnt;
	} dp_sts_t;

endpackage

### rtl/rrtp_ctrl.sv
module rrtp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  rrtp_pkg::dp_sts_t sts,
	output rrtp_pkg::dp_ctl_t ctl
);

	rrtp_pkg::state_t    state_q, state_nxt;
	rrtp_pkg::slot_idx_t cnt_q;
	logic                scan_last;

	assign scan_last = (cnt_q == rrtp_pkg::slot_idx_t'(rrtp_pkg::THREAD_SLOTS - 1));

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrtp_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Scan step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.load_in) begin
			cnt_q <= '0;
		end else if (ctl.scan_step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Next state and commands
	always_comb begin
		state_nxt = state_q;
		ctl       = '0;
		cmd_ready = 1'b0;
		unique case (state_q)
			rrtp_pkg::ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					ctl.load_in = 1'b1;
					state_nxt   = sts.in_tick ? rrtp_pkg::ST_SCAN : rrtp_pkg::ST_EXEC;
				end
			end
			rrtp_pkg::ST_EXEC: begin
				ctl.exec  = 1'b1;
				state_nxt = rrtp_pkg::ST_EMIT;
			end
			rrtp_pkg::ST_SCAN: begin
				ctl.scan_step = 1'b1;
				if (sts.hit || scan_last) begin
					state_nxt = rrtp_pkg::ST_DEMOTE;
				end
			end
			rrtp_pkg::ST_DEMOTE: begin
				ctl.demote = 1'b1;
				state_nxt  = rrtp_pkg::ST_COMMIT;
			end
			rrtp_pkg::ST_COMMIT: begin
				ctl.commit = 1'b1;
				state_nxt  = rrtp_pkg::ST_EMIT;
			end
			rrtp_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					ctl.emit  = 1'b1;
					state_nxt = rrtp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = rrtp_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/rrtp_datapath.sv
module rrtp_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rrtp_pkg::cmd_item_t  cmd,
	input  rrtp_pkg::dp_ctl_t    ctl,
	output rrtp_pkg::dp_sts_t    sts,
	output logic                 pick_valid,
	input  logic                 pick_ready,
	output rrtp_pkg::pick_item_t pick
);

	// Slot table and lock bitmap
	logic                  used_q     [rrtp_pkg::THREAD_SLOTS];
	rrtp_pkg::mode_t       mode_q     [rrtp_pkg::THREAD_SLOTS];
	logic                  began_q    [rrtp_pkg::THREAD_SLOTS];
	rrtp_pkg::lock_field_t wl_q       [rrtp_pkg::THREAD_SLOTS];
	logic                  lk_taken_q [rrtp_pkg::LOCK_COUNT];

	// Scheduler registers
	rrtp_pkg::slot_idx_t  run_slot_q, scan_pos_q, cursor_q, pick_q;
	logic                 run_idle_q, idle_began_q, got_q, out_valid_q;
	rrtp_pkg::used_cnt_t  used_cnt_q;
	rrtp_pkg::cmd_item_t  req_q;
	rrtp_pkg::pick_item_t res_q, out_q;

	// Shared read port and decode
	rrtp_pkg::slot_idx_t   rd_addr, req_slot_idx;
	rrtp_pkg::lock_idx_t   lk_idx, req_lock_idx;
	logic                  rd_used, rd_began;
	rrtp_pkg::mode_t       rd_mode;
	rrtp_pkg::lock_field_t rd_wl;
	logic                  lk_ok, lk_free, hit, hit_blk, do_free;
	logic                  req_slot_ok, req_lock_ok, req_block, same_got;

	function automatic rrtp_pkg::slot_idx_t next_slot(input rrtp_pkg::slot_idx_t s);
		if (s == rrtp_pkg::slot_idx_t'(rrtp_pkg::THREAD_SLOTS - 1)) begin
			return '0;
		end
		return s + 1'b1;
	endfunction

	assign req_slot_ok  = (int'(req_q.slot) < rrtp_pkg::THREAD_SLOTS);
	assign req_lock_ok  = (int'(req_q.lock_id) < rrtp_pkg::LOCK_COUNT);
	assign req_slot_idx = rrtp_pkg::slot_idx_t'(req_q.slot);
	assign req_lock_idx = rrtp_pkg::lock_idx_t'(req_q.lock_id);
	assign req_block    = (req_q.operation == rrtp_pkg::OP_BLOCK);

	// One table address per cycle, chosen by the current command
	always_comb begin
		priority if (ctl.scan_step) begin
			rd_addr = cursor_q;
		end else if (ctl.commit) begin
			rd_addr = pick_q;
		end else if (ctl.demote || (ctl.exec && req_block)) begin
			rd_addr = run_slot_q;
		end else begin
			rd_addr = req_slot_idx;
		end
	end

	assign rd_used  = used_q[rd_addr];
	assign rd_mode  = mode_q[rd_addr];
	assign rd_began = began_q[rd_addr];
	assign rd_wl    = wl_q[rd_addr];
	assign lk_idx   = rrtp_pkg::lock_idx_t'(rd_wl);
	assign lk_ok    = (int'(rd_wl) < rrtp_pkg::LOCK_COUNT);
	assign lk_free  = !lk_taken_q[lk_idx];

	// Scan decision for the slot under the cursor
	assign hit_blk = rd_used && (rd_mode == rrtp_pkg::MODE_BLOCKED) && lk_ok && lk_free;
	assign hit     = rd_used && ((rd_mode == rrtp_pkg::MODE_READY) || hit_blk ||
		((rd_mode == rrtp_pkg::MODE_RUNNING) &&
		(used_cnt_q == rrtp_pkg::used_cnt_t'(1))));
	assign do_free = rd_used && (rd_mode == rrtp_pkg::MODE_TERMINATED) &&
		!(!run_idle_q && (run_slot_q == cursor_q));

	assign same_got = !run_idle_q && (run_slot_q == pick_q);

	// Control state and table updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rrtp_pkg::THREAD_SLOTS; i++) begin
				used_q[i]  <= 1'b0;
				mode_q[i]  <= rrtp_pkg::MODE_SUSPENDED;
				began_q[i] <= 1'b0;
			end
			for (int i = 0; i < rrtp_pkg::LOCK_COUNT; i++) begin
				lk_taken_q[i] <= 1'b0;
			end
			run_slot_q   <= '0;
			run_idle_q   <= 1'b1;
			idle_began_q <= 1'b0;
			scan_pos_q   <= '0;
			used_cnt_q   <= '0;
			got_q        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			// Result register: a new result wins over the transfer of the old one
			if (ctl.emit) begin
				out_valid_q <= 1'b1;
			end else if (pick_ready) begin
				out_valid_q <= 1'b0;
			end
			if (ctl.load_in) begin
				got_q <= 1'b0;
			end
			// Events
			if (ctl.exec) begin
				unique case (rrtp_pkg::op_code_t'(req_q.operation))
					rrtp_pkg::OP_ADMIT: begin
						if (req_slot_ok && !rd_used) begin
							used_q[rd_addr]  <= 1'b1;
							mode_q[rd_addr]  <= rrtp_pkg::MODE_READY;
							began_q[rd_addr] <= 1'b0;
							used_cnt_q       <= used_cnt_q + 1'b1;
						end
					end
					rrtp_pkg::OP_SUSPEND: begin
						if (req_slot_ok && rd_used) begin
							mode_q[rd_addr] <= rrtp_pkg::MODE_SUSPENDED;
						end
					end
					rrtp_pkg::OP_RESUME: begin
						if (req_slot_ok && rd_used) begin
							mode_q[rd_addr] <= rrtp_pkg::MODE_READY;
						end
					end
					rrtp_pkg::OP_TERMINATE: begin
						if (req_slot_ok && rd_used) begin
							mode_q[rd_addr] <= rrtp_pkg::MODE_TERMINATED;
						end
					end
					rrtp_pkg::OP_BLOCK: begin
						if (req_lock_ok && !run_idle_q) begin
							mode_q[rd_addr] <= rrtp_pkg::MODE_BLOCKED;
						end
					end
					rrtp_pkg::OP_FREE_LOCK: begin
						if (req_lock_ok) begin
							lk_taken_q[req_lock_idx] <= 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
			// One slot of the round robin scan
			if (ctl.scan_step) begin
				if (hit) begin
					got_q      <= 1'b1;
					scan_pos_q <= cursor_q;
					if (hit_blk) begin
						lk_taken_q[lk_idx] <= 1'b1;
					end
				end
				if (do_free) begin
					used_q[rd_addr] <= 1'b0;
					used_cnt_q      <= used_cnt_q - 1'b1;
				end
			end
			// Current thread drops back to ready
			if (ctl.demote) begin
				if (!run_idle_q && rd_used && (rd_mode == rrtp_pkg::MODE_RUNNING)) begin
					mode_q[rd_addr] <= rrtp_pkg::MODE_READY;
				end
			end
			// Chosen thread takes over
			if (ctl.commit) begin
				if (got_q) begin
					mode_q[rd_addr]  <= rrtp_pkg::MODE_RUNNING;
					began_q[rd_addr] <= 1'b1;
					run_slot_q       <= pick_q;
					run_idle_q       <= 1'b0;
				end else begin
					idle_began_q <= 1'b1;
					run_idle_q   <= 1'b1;
				end
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			req_q    <= cmd;
			cursor_q <= next_slot(scan_pos_q);
		end
		if (ctl.exec && req_block && req_lock_ok && !run_idle_q) begin
			wl_q[rd_addr] <= req_q.lock_id;
		end
		if (ctl.scan_step) begin
			cursor_q <= next_slot(cursor_q);
			if (hit) begin
				pick_q <= cursor_q;
			end
		end
		if (ctl.exec) begin
			res_q.picked_slot <= run_idle_q ? '0 : rrtp_pkg::slot_field_t'(run_slot_q);
			res_q.picked_idle <= run_idle_q;
			res_q.first_entry <= 1'b0;
			res_q.switched    <= 1'b0;
		end
		if (ctl.commit) begin
			if (got_q) begin
				res_q.picked_slot <= rrtp_pkg::slot_field_t'(pick_q);
				res_q.picked_idle <= 1'b0;
				res_q.first_entry <= !rd_began;
				res_q.switched    <= !same_got || !rd_began;
			end else begin
				res_q.picked_slot <= '0;
				res_q.picked_idle <= 1'b1;
				res_q.first_entry <= !idle_began_q;
				res_q.switched    <= !run_idle_q || !idle_began_q;
			end
		end
		if (ctl.emit) begin
			out_q <= res_q;
		end
	end

	// Status and result port
	assign sts.in_tick  = (cmd.operation == rrtp_pkg::OP_TICK);
	assign sts.hit      = hit;
	assign sts.out_free = !out_valid_q || pick_ready;
	assign sts.used_cnt = used_cnt_q;

	assign pick_valid = out_valid_q;
	assign pick       = out_q;

endmodule

### rtl/round_robin_thread_picker_core.sv
// Round robin thread picker. Takes one scheduler event per transfer on cmd and returns
// exactly one pick transfer per event. Events other than a tick (admit, suspend, resume,
// block current, terminate, free lock) pass through the execute and emit states. A tick
// passes through the scan, demote, commit and emit states: the scan reads one table slot per
// cycle, starting after the last pick and stopping on the first thread taken or on the last
// slot, so it examines from 1 to THREAD_SLOTS slots. One event is in work at a time; a
// new event is accepted the cycle after the previous result enters the output register,
// even while that result still waits for pick_ready. No clearing pass after reset.
`include "assert_macros.svh"

module round_robin_thread_picker_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  rrtp_pkg::cmd_item_t  cmd,
	output logic                 pick_valid,
	input  logic                 pick_ready,
	output rrtp_pkg::pick_item_t pick
);

	rrtp_pkg::dp_ctl_t ctl;
	rrtp_pkg::dp_sts_t sts;

	// Sequencer
	rrtp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	// Slot table, scan and result register
	rrtp_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.ctl        (ctl),
		.sts        (sts),
		.pick_valid (pick_valid),
		.pick_ready (pick_ready),
		.pick       (pick)
	);

	// Checks
	`RRTP_ASSERT_IMPLY(a_used_cnt_range, clk, arst_n, 1'b1, int'(sts.used_cnt) <= rrtp_pkg::THREAD_SLOTS)
	`RRTP_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, cmd_valid && cmd_ready, !cmd_ready)
	`RRTP_ASSERT_IMPLY(a_idle_slot_zero, clk, arst_n, pick_valid && pick.picked_idle, pick.picked_slot == '0)
	`RRTP_ASSERT_IMPLY(a_first_switches, clk, arst_n, pick_valid && pick.first_entry, pick.switched)

endmodule
